// ===== rtl/c3zb_pkg.sv =====
`default_nettype none

package c3zb_pkg;

  localparam int MAX_SIZE  = 64;
  localparam int PIXEL_W   = 16;
  localparam int COEF_W    = 8;
  localparam int PROD_W    = PIXEL_W + COEF_W;
  localparam int VALUE_W   = 27;
  localparam int POS_W     = 6;
  localparam int SIZE_W    = 7;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_RES   = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET       = SIZE_W'(9);
  localparam logic [CFG_W-1:0]  COEF_TOP_RESET   = 24'h00FF00;
  localparam logic [CFG_W-1:0]  COEF_MID_RESET   = 24'hFF04FF;
  localparam logic [CFG_W-1:0]  COEF_BOT_RESET   = 24'h00FF00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_SIZE  = 2'd0,
    REG_COEF_TOP    = 2'd1,
    REG_COEF_MID    = 2'd2,
    REG_COEF_BOTTOM = 2'd3
  } cfg_reg_t;

  // Per-item bookkeeping carried alongside the arithmetic.
  // mask bit 0: centre result, 1: last-column zero, 2: last-row zero, 3: corner zero
  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   nm1;
    logic [NUM_RES-1:0] mask;
    logic               interior;
  } c3zb_meta_t;

  typedef struct packed {
    c3zb_meta_t          meta;
    logic [VALUE_W-1:0]  sum;
  } c3zb_item_t;

endpackage

`default_nettype wire

// ===== rtl/c3zb_emit.sv =====
`default_nettype none

module c3zb_emit
  import c3zb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               ld_valid,
  input  wire c3zb_item_t         ld_item,
  output logic                    ld_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [VALUE_W-1:0]      value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    last_of_run,
  output logic                    frame_done
);

  logic [NUM_RES-1:0] emask;
  c3zb_item_t         item;

  logic               out_free;
  logic               send;
  logic [NUM_RES-1:0] sel;
  logic [NUM_RES-1:0] rest;
  logic [VALUE_W-1:0] sel_value;
  logic [POS_W-1:0]   sel_row;
  logic [POS_W-1:0]   sel_col;

  assign out_free = !out_valid || out_ready;
  assign send     = out_free && (emask != '0);
  assign sel      = emask & (~emask + NUM_RES'(1));  // lowest pending result
  assign rest     = emask & ~sel;
  assign ld_ready = (emask == '0) || (send && (rest == '0));

  always_comb begin
    sel_value = '0;
    sel_row   = item.meta.nm1;
    sel_col   = item.meta.nm1;
    if (sel[0]) begin
      sel_value = item.meta.interior ? item.sum : '0;
      sel_row   = item.meta.row - POS_W'(1);
      sel_col   = item.meta.col - POS_W'(1);
    end else if (sel[1]) begin
      sel_row   = item.meta.row - POS_W'(1);
    end else if (sel[2]) begin
      sel_col   = item.meta.col - POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emask <= '0;
    end else if (ld_valid && ld_ready) begin
      emask <= ld_item.meta.mask;
    end else if (send) begin
      emask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      item <= ld_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      value       <= sel_value;
      out_row     <= sel_row;
      out_col     <= sel_col;
      last_of_run <= (rest == '0);
      frame_done  <= sel[3];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/conv3x3_zero_border_top.sv =====
//  channel | direction | handshake              | payload
//  ------- | --------- | ---------------------- | ---------------------------------------
//  input   | in        | in_valid / in_ready    | pixel
//  output  | out       | out_valid / out_ready  | value, out_row, out_col, last_of_run,
//          |           |                        | frame_done
//  config  | in        | cfg_we                 | cfg_index, cfg_data
//
//  One pixel a cycle while nothing stalls; after its transfer in, the first result of a
//  pixel goes through the line store read, products, sum into the hold register, output register.
//  A last-column pixel past row 0 yields 2 results and a last-row one up to 4, sent one
//  a cycle through the output register while out_ready is high; upstream is held for those extra cycles.
//  The line stores are single-write memories read at the pixel's column on the
//  transfer in; written back one stage later. No clearing pass after reset.
//  Output stall backs up through the stages to in_ready.
`default_nettype none

module conv3x3_zero_border_top
  import c3zb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIXEL_W-1:0]   pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [VALUE_W-1:0]        value,
  output logic [POS_W-1:0]          out_row,
  output logic [POS_W-1:0]          out_col,
  output logic                      last_of_run,
  output logic                      frame_done
);

  // configuration
  logic [SIZE_W-1:0] image_size;
  logic [CFG_W-1:0]  coef_row [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= SIZE_RESET;
      coef_row[0] <= COEF_TOP_RESET;
      coef_row[1] <= COEF_MID_RESET;
      coef_row[2] <= COEF_BOT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_SIZE:  image_size  <= cfg_data[SIZE_W-1:0];
        REG_COEF_TOP:    coef_row[0] <= cfg_data;
        REG_COEF_MID:    coef_row[1] <= cfg_data;
        REG_COEF_BOTTOM: coef_row[2] <= cfg_data;
      endcase
    end
  end

  // N-1 with the size clamped to 3..MAX_SIZE
  logic [SIZE_W-1:0] size_m1;
  logic [POS_W-1:0]  nm1;

  assign size_m1 = image_size - SIZE_W'(1);

  always_comb begin
    if (image_size < SIZE_W'(3)) begin
      nm1 = POS_W'(2);
    end else if (image_size > SIZE_W'(MAX_SIZE)) begin
      nm1 = POS_W'(MAX_SIZE - 1);
    end else begin
      nm1 = size_m1[POS_W-1:0];
    end
  end

  // position counters
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] col_count;
  logic             last_col;
  logic             last_row;
  logic             in_xfer;

  assign last_col = col_count >= nm1;
  assign last_row = row_count >= nm1;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_xfer) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + POS_W'(1);
      end else begin
        col_count <= col_count + POS_W'(1);
      end
    end
  end

  // pipeline control
  logic       a_valid;
  logic       b_valid;
  logic       a_go;
  logic       a_adv;
  logic       b_adv;
  logic       ld_ready;

  assign a_go     = !b_valid || ld_ready;
  assign a_adv    = a_valid && a_go;
  assign b_adv    = b_valid && ld_ready;
  assign in_ready = !a_valid || a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
    end
  end

  // stage A: line store read data, pixel and bookkeeping
  logic [PIXEL_W-1:0] a_pixel;
  c3zb_meta_t         a_meta;
  c3zb_meta_t         meta_in;

  always_comb begin
    meta_in.row      = row_count;
    meta_in.col      = col_count;
    meta_in.nm1      = nm1;
    meta_in.mask[0]  = (row_count != '0) && (col_count != '0);
    meta_in.mask[1]  = (row_count != '0) && last_col;
    meta_in.mask[2]  = last_row && (col_count != '0);
    meta_in.mask[3]  = last_row && last_col;
    meta_in.interior = (row_count >= POS_W'(2)) && (col_count >= POS_W'(2));
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_pixel <= pixel;
      a_meta  <= meta_in;
    end
  end

  // line stores: read on transfer in, written back when stage A moves on.
  // Consecutive pixels never share a column, so read and write never collide.
  logic [PIXEL_W-1:0] mem_older [MAX_SIZE];
  logic [PIXEL_W-1:0] mem_newer [MAX_SIZE];
  logic [PIXEL_W-1:0] rd_older;
  logic [PIXEL_W-1:0] rd_newer;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      mem_older[a_meta.col] <= rd_newer;
    end
    if (in_xfer) begin
      rd_older <= mem_older[col_count];
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      mem_newer[a_meta.col] <= a_pixel;
    end
    if (in_xfer) begin
      rd_newer <= mem_newer[col_count];
    end
  end

  // window of the two previous columns, shifted as each pixel leaves stage A
  logic [PIXEL_W-1:0] win0 [3];
  logic [PIXEL_W-1:0] win1 [3];
  logic [PIXEL_W-1:0] cur  [3];

  assign cur[0] = rd_older;
  assign cur[1] = rd_newer;
  assign cur[2] = a_pixel;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      for (int i = 0; i < 3; i++) begin
        win0[i] <= win1[i];
        win1[i] <= cur[i];
      end
    end
  end

  // stage B: nine registered products
  logic signed [PROD_W-1:0] prod [3][3];
  c3zb_meta_t               b_meta;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_meta <= a_meta;
      for (int i = 0; i < 3; i++) begin
        prod[i][0] <= $signed(win0[i]) * $signed(coef_row[i][COEF_W*0 +: COEF_W]);
        prod[i][1] <= $signed(win1[i]) * $signed(coef_row[i][COEF_W*1 +: COEF_W]);
        prod[i][2] <= $signed(cur[i])  * $signed(coef_row[i][COEF_W*2 +: COEF_W]);
      end
    end
  end

  logic signed [VALUE_W-1:0] row_sum [3];
  c3zb_item_t                b_item;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = VALUE_W'(prod[i][0]) + VALUE_W'(prod[i][1]) + VALUE_W'(prod[i][2]);
    end
    b_item.meta = b_meta;
    b_item.sum  = row_sum[0] + row_sum[1] + row_sum[2];
  end

  c3zb_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .ld_valid    (b_valid),
    .ld_item     (b_item),
    .ld_ready    (ld_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

  // a new pixel must never read the column being written back in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && a_valid) |-> (col_count != a_meta.col))
    else $error("line store read and write hit the same column");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> (last_of_run && (out_row == out_col)))
    else $error("frame end not on the corner result");

  // results of one pixel go out without gaps while the sink keeps taking them
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> out_valid)
    else $error("gap inside a run of results");

endmodule

`default_nettype wire
